// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They compile away under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define SHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, clk, rst, prop, msg)
`define SHA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/sha224_pkg.sv -----
// ---------------------------------------------------------------------------
// SHA-224 package
// Sequencer states, initial hash values, round constants and round functions.
// ---------------------------------------------------------------------------
package sha224_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam logic [31:0] PAD_WORD          = 32'h8000_0000;
   localparam logic [2:0]  FULL_BYTES        = 3'd4;
   localparam logic [2:0]  DIGEST_LAST_INDEX = 3'd6;
   localparam logic [3:0]  LEN_HI_SLOT       = 4'd14;
   localparam logic [3:0]  LAST_SLOT         = 4'd15;
   localparam logic [5:0]  LAST_ROUND        = 6'd63;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

// ----- rtl/sha224_digest.sv -----
// A non-final request is taken as soon as it is offered in ST_IDLE; the sixteenth word of a block
// is followed by the rounds and a fold, during which req_ready is low and no word is taken.
// The final request adds the pad words, one or two blocks of rounds and folds, then seven
// digest responses, one per cycle while rsp_ready is high. The sustained rate is set by the
// single round unit working one round per cycle.
// Reset is synchronous and active high; it loads the initial hash values, with no clearing pass.
// ---------------------------------------------------------------------------
// SHA-224 digest engine
// Gathers big-endian message words into a 16-word window, runs the 64-round
// compression through one shared round unit, pads the message and returns
// the seven digest words as separate responses.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha224_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_message_word,
   input  logic [2:0]  req_valid_bytes,
   input  logic        req_final_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_digest_index,
   output logic        rsp_digest_last
);

   // Sequencer state and control registers.
   sha224_pkg::state_type state_ff, state_in;
   logic [63:0] bitlen_ff, bitlen_in;   // message length in bits, wraps
   logic [3:0]  pos_ff, pos_in;         // next free slot of the window
   logic [5:0]  rnd_ff, rnd_in;         // round counter
   logic [2:0]  idx_ff, idx_in;         // digest word being offered
   logic        tail_ff, tail_in;       // the final request has been taken
   logic        pad80_ff, pad80_in;     // the pad word still has to go in
   logic        lenhi_ff, lenhi_in;     // the upper length word is in the window
   logic        lendone_ff, lendone_in; // the length words are in the window
   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];

   // Datapath registers; they need no reset since every slot is written before it is read.
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];

   // The window is a shift line: the round unit always takes slot 0, and
   // new words, whether from a request or from the schedule, enter at slot 15.
   logic        shift_en;
   logic [31:0] shift_word;

   logic [2:0]  vclamp;
   logic [31:0] last_word;
   logic [31:0] sched_word;
   logic [31:0] t1, t2, ch, maj;

   // Byte counts above four behave as four.
   always_comb begin
      if (req_valid_bytes inside {[3'd4:3'd7]}) begin
         vclamp = sha224_pkg::FULL_BYTES;
      end else begin
         vclamp = req_valid_bytes;
      end
   end

   // The final word keeps its valid leading bytes and takes the pad byte right after them.
   // With four valid bytes the pad needs a word of its own.
   always_comb begin
      case (vclamp)
         3'd0:    last_word = sha224_pkg::PAD_WORD;
         3'd1:    last_word = {req_message_word[31:24], 24'h80_0000};
         3'd2:    last_word = {req_message_word[31:16], 16'h8000};
         3'd3:    last_word = {req_message_word[31:8], 8'h80};
         default: last_word = req_message_word;
      endcase
   end

   // Shared round unit: one SHA-256 round and one schedule word per cycle.
   always_comb begin
      sched_word = win_ff[0] + sha224_pkg::small_sigma0(win_ff[1]) + win_ff[9]
                 + sha224_pkg::small_sigma1(win_ff[14]);
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + sha224_pkg::big_sigma1(work_ff[4]) + ch
          + sha224_pkg::ROUND_K[rnd_ff] + win_ff[0];
      t2  = sha224_pkg::big_sigma0(work_ff[0]) + maj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sha224_pkg::ST_IDLE;
         bitlen_ff  <= '0;
         pos_ff     <= '0;
         rnd_ff     <= '0;
         idx_ff     <= '0;
         tail_ff    <= 1'b0;
         pad80_ff   <= 1'b0;
         lenhi_ff   <= 1'b0;
         lendone_ff <= 1'b0;
         hash_ff    <= sha224_pkg::HASH_INIT;
      end else begin
         state_ff   <= state_in;
         bitlen_ff  <= bitlen_in;
         pos_ff     <= pos_in;
         rnd_ff     <= rnd_in;
         idx_ff     <= idx_in;
         tail_ff    <= tail_in;
         pad80_ff   <= pad80_in;
         lenhi_ff   <= lenhi_in;
         lendone_ff <= lendone_in;
         hash_ff    <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      work_ff <= work_in;
   end

   // Sequencer: next state, control updates and handshake outputs.
   always_comb begin
      state_in   = state_ff;
      bitlen_in  = bitlen_ff;
      pos_in     = pos_ff;
      rnd_in     = rnd_ff;
      idx_in     = idx_ff;
      tail_in    = tail_ff;
      pad80_in   = pad80_ff;
      lenhi_in   = lenhi_ff;
      lendone_in = lendone_ff;
      hash_in    = hash_ff;
      work_in    = work_ff;
      shift_en   = 1'b0;
      shift_word = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;

      case (state_ff)
         sha224_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               shift_en = 1'b1;
               pos_in   = pos_ff + 4'd1;
               if (req_final_word) begin
                  shift_word = last_word;
                  bitlen_in  = bitlen_ff + {58'd0, vclamp, 3'b000};
                  tail_in    = 1'b1;
                  pad80_in   = (vclamp == sha224_pkg::FULL_BYTES);
                  state_in   = sha224_pkg::ST_PAD;
               end else begin
                  shift_word = req_message_word;
                  bitlen_in  = bitlen_ff + 64'd32;
               end
               if (pos_ff == sha224_pkg::LAST_SLOT) begin
                  state_in = sha224_pkg::ST_ROUND;
                  rnd_in   = '0;
                  work_in  = hash_ff;
               end
            end
         end

         // One padding word per cycle: the pad word if it is still due, zero fill,
         // then the upper and lower halves of the bit length in the last two slots.
         // When the pad byte or the pad word took slot fourteen, the last slot is
         // zero filled and the length goes into a further block.
         sha224_pkg::ST_PAD: begin
            shift_en = 1'b1;
            pos_in   = pos_ff + 4'd1;
            if (pad80_ff) begin
               shift_word = sha224_pkg::PAD_WORD;
               pad80_in   = 1'b0;
            end else if (pos_ff == sha224_pkg::LEN_HI_SLOT) begin
               shift_word = bitlen_ff[63:32];
               lenhi_in   = 1'b1;
            end else if ((pos_ff == sha224_pkg::LAST_SLOT) && lenhi_ff) begin
               shift_word = bitlen_ff[31:0];
               lendone_in = 1'b1;
            end else begin
               shift_word = '0;
            end
            if (pos_ff == sha224_pkg::LAST_SLOT) begin
               state_in = sha224_pkg::ST_ROUND;
               rnd_in   = '0;
               work_in  = hash_ff;
            end
         end

         sha224_pkg::ST_ROUND: begin
            shift_en   = 1'b1;
            shift_word = sched_word;
            for (int i = 7; i > 0; i--) begin
               work_in[i] = work_ff[i-1];
            end
            work_in[4] = work_ff[3] + t1;
            work_in[0] = t1 + t2;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == sha224_pkg::LAST_ROUND) begin
               state_in = sha224_pkg::ST_FOLD;
            end
         end

         // Fold the working words into the chaining value, then take more words, pad, or emit the digest.
         sha224_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            if (lendone_ff) begin
               state_in = sha224_pkg::ST_EMIT;
               idx_in   = '0;
            end else if (tail_ff) begin
               state_in = sha224_pkg::ST_PAD;
            end else begin
               state_in = sha224_pkg::ST_IDLE;
            end
         end

         // The digest is read straight from the hash registers, which hold still here.
         sha224_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == sha224_pkg::DIGEST_LAST_INDEX) begin
                  state_in   = sha224_pkg::ST_IDLE;
                  hash_in    = sha224_pkg::HASH_INIT;
                  bitlen_in  = '0;
                  pos_in     = '0;
                  tail_in    = 1'b0;
                  pad80_in   = 1'b0;
                  lenhi_in   = 1'b0;
                  lendone_in = 1'b0;
               end
            end
         end

         default: begin
            state_in = sha224_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 15; i++) begin
         win_in[i] = shift_en ? win_ff[i+1] : win_ff[i];
      end
      win_in[15] = shift_en ? shift_word : win_ff[15];
   end

   assign rsp_digest_word  = hash_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == sha224_pkg::DIGEST_LAST_INDEX);

   // A compression only ever starts on a full window, so the slot count has wrapped.
   `SHA_ASSERT(a_round_pos_zero, clock, reset, (state_ff == sha224_pkg::ST_ROUND) |-> (pos_ff == 4'd0), "window slot count not zero during rounds")
   // Every compression starts at round zero.
   `SHA_ASSERT(a_round_start, clock, reset, ((state_ff == sha224_pkg::ST_ROUND) && ($past(state_ff) != sha224_pkg::ST_ROUND)) |-> (rnd_ff == 6'd0), "compression did not start at round zero")
   // Requests and responses are never offered together.
   `SHA_ASSERT_ALWAYS(a_one_side, clock, !(req_ready && rsp_valid), "request and response sides active together")
   // After the last digest word the engine is rearmed for a new message.
   `SHA_ASSERT(a_rearm, clock, reset, (rsp_valid && rsp_ready && rsp_digest_last) |=> (req_ready && (bitlen_ff == 64'd0) && (pos_ff == 4'd0)), "engine not rearmed after digest")
   // Results are only offered once the length has gone into a block.
   `SHA_ASSERT(a_emit_after_len, clock, reset, rsp_valid |-> (lendone_ff && tail_ff), "digest offered before the message was padded")

endmodule

// ----- tb/tb_sha224_digest.sv -----
// ---------------------------------------------------------------------------
// SHA-224 digest engine testbench
// Drives whole messages into sha224_digest as requests and checks every
// digest word against the bench's own SHA-224 model or a known vector. A
// short table of directed requests comes first. Random messages of mixed
// length follow, under three idling phases and one long response hold-off.
// ---------------------------------------------------------------------------
module tb_sha224_digest;

   // Number of cycles the receiver refuses responses during the hold-off.
   localparam int HOLD_OFF_CYCLES = 400;
   // No new message starts once this many requests have been accepted.
   localparam int REQUEST_TARGET  = 370;
   // Quiet cycles after the last digest word, to catch stray responses.
   localparam int DRAIN_CYCLES    = 100;

   // SHA-224 initial chaining value and SHA-256 round constants. They are
   // kept here so that a wrong table in the design cannot hide itself.
   localparam logic [31:0] IV_224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // One digest word as it should appear on the response channel.
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   // One row of the directed table. Where known is set, the seven digest
   // words are typed in from the published test vectors and take the place
   // of the model's prediction.
   typedef struct packed {
      logic [31:0]  word;
      logic [2:0]   nbytes;
      logic         fin;
      logic         known;
      logic [223:0] digest;
   } stim_row_type;

   localparam logic [223:0] DIGEST_EMPTY =
      224'hd14a028c_2a3a2bc9_476102bb_288234c4_15a2b01f_828ea62a_c5b3e42f;
   localparam logic [223:0] DIGEST_ABC =
      224'h23097d22_3405d822_8642a477_bda255b3_2aadbce4_bda0b3f7_e36c9da7;

   localparam int DIRECTED_ROWS = 23;

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // The empty message straight after reset: one final request with no bytes.
      '{32'h0000_0000, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY},
      // "abc" with a stray fourth byte, which the engine must mask off.
      '{32'h6162_63a5, 3'd3, 1'b1, 1'b1, DIGEST_ABC},
      // A byte count above four on a final request counts as four.
      '{32'hffff_ffff, 3'd7, 1'b1, 1'b0, '0},
      // A non-final request is always four bytes, even with a count of zero.
      '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd1, 1'b1, 1'b0, '0},
      '{32'h1234_5678, 3'd2, 1'b1, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b1, 1'b0, '0},
      '{32'ha5a5_a5a5, 3'd5, 1'b1, 1'b0, '0},
      '{32'h5a5a_5a5a, 3'd6, 1'b1, 1'b0, '0},
      // Thirteen words and then a full final word: the pad word lands in the
      // length slot, so the length needs a second block of its own.
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd7, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd0, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0000_0000, 3'd4, 1'b0, 1'b0, '0},
      '{32'hffff_ffff, 3'd4, 1'b0, 1'b0, '0},
      '{32'h0f0f_0f0f, 3'd4, 1'b1, 1'b0, '0}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_message_word;
   logic [2:0]  req_valid_bytes;
   logic        req_final_word;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_digest_index;
   logic        rsp_digest_last;

   sha224_digest u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_message_word (req_message_word),
      .req_valid_bytes  (req_valid_bytes),
      .req_final_word   (req_final_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_digest_word  (rsp_digest_word),
      .rsp_digest_index (rsp_digest_index),
      .rsp_digest_last  (rsp_digest_last)
   );

   // -------------------------------------------------------------------------
   // SHA-224 model. It holds its own chaining value, the sixteen-word
   // schedule window, the running bit count and the next free window slot.
   // -------------------------------------------------------------------------
   logic [31:0] chain_value [8];
   logic [31:0] msg_schedule [16];
   logic [63:0] msg_bit_count;
   logic [3:0]  fill_slot;
   logic [31:0] predicted_digest [7];

   // Digest words still owed by the engine, oldest first.
   digest_word_type digest_words_due [$];

   int mismatch_count = 0;
   int requests_sent  = 0;
   int req_idle_pct   = 14;
   int rsp_idle_pct   = 49;
   bit hold_off_pending = 1'b0;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // Starts a fresh message: the chaining value goes back to the SHA-224
   // start value and the bit count and window position go back to zero.
   function automatic void restart_digest();
      for (int i = 0; i < 8; i++) chain_value[i] = IV_224[i];
      msg_bit_count = '0;
      fill_slot     = '0;
   endfunction

   // The 64 rounds on a full window. The window itself is rewritten with the
   // expanded schedule as the rounds go, just as the hardware does.
   function automatic void compress_block();
      logic [31:0] v [8];
      logic [31:0] w, w15, w2, t1, t2;
      for (int i = 0; i < 8; i++) v[i] = chain_value[i];
      for (int t = 0; t < 64; t++) begin
         if (t < 16) begin
            w = msg_schedule[t];
         end else begin
            w15 = msg_schedule[(t - 15) & 15];
            w2  = msg_schedule[(t - 2) & 15];
            w = msg_schedule[t & 15]
              + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
              + msg_schedule[(t - 7) & 15]
              + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
            msg_schedule[t & 15] = w;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[t] + w;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i - 1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_value[i] = chain_value[i] + v[i];
   endfunction

   function automatic void load_word(input logic [31:0] w);
      msg_schedule[fill_slot] = w;
      fill_slot = fill_slot + 4'd1;
      if (fill_slot == 4'd0) compress_block();
   endfunction

   // Takes one accepted request into the model. Returns 1 when the request
   // closes a message, with the seven digest words left in predicted_digest.
   function automatic bit absorb_request(input logic [31:0] word,
                                         input logic [2:0] nbytes,
                                         input logic fin);
      logic [2:0]  nb;
      logic [31:0] keep;
      if (!fin) begin
         msg_bit_count = msg_bit_count + 64'd32;
         load_word(word);
         return 1'b0;
      end
      nb = (nbytes > 3'd4) ? 3'd4 : nbytes;
      msg_bit_count = msg_bit_count + 64'(8 * nb);
      if (nb == 3'd4) begin
         load_word(word);
         load_word(32'h8000_0000);
      end else begin
         // Bytes past the valid count are cleared before the pad byte goes in.
         keep = (nb == 3'd0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - nb)));
         load_word((word & keep) | (32'h8000_0000 >> (8 * nb)));
      end
      while (fill_slot != 4'd14) load_word(32'h0);
      load_word(msg_bit_count[63:32]);
      load_word(msg_bit_count[31:0]);
      for (int k = 0; k < 7; k++) predicted_digest[k] = chain_value[k];
      restart_digest();
      return 1'b1;
   endfunction

   // -------------------------------------------------------------------------
   // Clock, reset and the time limit.
   // -------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Even the slowest correct run needs well under a tenth of this.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side. A request is offered at a falling edge and held until the
   // rising edge at which req_ready is seen high; only then does the model
   // take it in. The valid line is only lowered by an idle cycle or after the
   // last request, so it never gets two assignments in the same time step.
   // -------------------------------------------------------------------------
   task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                               input logic fin, input logic known,
                               input logic [223:0] known_digest);
      digest_word_type due_word;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_message_word <= word;
      req_valid_bytes  <= nbytes;
      req_final_word   <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (absorb_request(word, nbytes, fin)) begin
         for (int k = 0; k < 7; k++) begin
            due_word.word  = known ? known_digest[223 - 32 * k -: 32] : predicted_digest[k];
            due_word.index = 3'(k);
            due_word.last  = (k == 6);
            digest_words_due.push_back(due_word);
         end
      end
      requests_sent++;
      @(negedge clock);
   endtask

   initial begin
      int msg_len;
      int shape;
      bit hold_off_done;
      hold_off_done    = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_message_word = '0;
      req_valid_bytes  = '0;
      req_final_word   = 1'b0;
      restart_digest();
      for (int i = 0; i < 16; i++) msg_schedule[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: the table, one request per row.
      foreach (directed_rows[r]) begin
         send_request(directed_rows[r].word, directed_rows[r].nbytes, directed_rows[r].fin,
                      directed_rows[r].known, directed_rows[r].digest);
      end

      // Random part: whole messages with random content. Lengths cluster
      // around the block boundaries, where the padding decides whether a
      // second block is needed, and a few messages span several blocks.
      while (requests_sent < REQUEST_TARGET) begin
         // The idling phases follow the number of requests sent so far.
         if (requests_sent < REQUEST_TARGET / 3) begin
            req_idle_pct = 14;
            rsp_idle_pct = 49;
         end else if (requests_sent < 2 * REQUEST_TARGET / 3) begin
            req_idle_pct = 49;
            rsp_idle_pct = 14;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            // With nobody idling, the receiver once stops taking responses
            // for a long while, so that a finished digest blocks the engine
            // and the request channel backs up behind it.
            if (!hold_off_done) begin
               hold_off_pending = 1'b1;
               hold_off_done    = 1'b1;
            end
         end
         shape = $urandom_range(99);
         if (shape < 50)      msg_len = $urandom_range(0, 16);
         else if (shape < 80) msg_len = 12 + $urandom_range(0, 4);
         else if (shape < 95) msg_len = $urandom_range(17, 34);
         else                 msg_len = $urandom_range(35, 48);
         for (int i = 0; i < msg_len; i++) begin
            // Now and then a non-final request carries an odd byte count,
            // which the engine must disregard.
            send_request($urandom(),
                         ($urandom_range(9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4,
                         1'b0, 1'b0, '0);
         end
         send_request($urandom(), 3'($urandom_range(0, 7)), 1'b1, 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // -------------------------------------------------------------------------
   // Response side. rsp_ready changes only at the falling edge; the hold-off
   // is counted here, in its own process, while the request side carries on.
   // -------------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_pending = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s: got %h, wanted %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Every accepted response is held against the oldest digest word owed.
   always @(posedge clock) begin
      digest_word_type due_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (digest_words_due.size() == 0) begin
            report_mismatch("response with none outstanding", rsp_digest_word, '0);
         end else begin
            due_word = digest_words_due.pop_front();
            if (rsp_digest_word !== due_word.word)
               report_mismatch("digest word", rsp_digest_word, due_word.word);
            if (rsp_digest_index !== due_word.index)
               report_mismatch("digest index", 32'(rsp_digest_index), 32'(due_word.index));
            if (rsp_digest_last !== due_word.last)
               report_mismatch("digest last flag", 32'(rsp_digest_last), 32'(due_word.last));
         end
      end
   end

endmodule
